/* src/mail_command_tokenizer_core_macros.svh */
// Assertion helpers shared by the tokenizer modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef MAIL_COMMAND_TOKENIZER_CORE_MACROS_SVH
`define MAIL_COMMAND_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mct_pkg.sv */
package mct_pkg;

  // Token count saturation
  localparam int unsigned MAX_TOKENS = 255;
  localparam logic [7:0] TOKEN_LIMIT = (MAX_TOKENS < 255) ? 8'(MAX_TOKENS) : 8'd255;

  // Queue between front and back end; depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Scan modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_PLAIN  = 3'd1;
  localparam logic [2:0] MODE_ADDR   = 3'd2;
  localparam logic [2:0] MODE_ADDR_Q = 3'd3;
  localparam logic [2:0] MODE_LIT    = 3'd4;
  localparam logic [2:0] MODE_LIT_Q  = 3'd5;
  localparam logic [2:0] MODE_QSTR   = 3'd6;

  // Token kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // Byte classes, decided by the front end
  typedef enum logic [3:0] {
    CLS_SPACE,
    CLS_LT,
    CLS_LBRACK,
    CLS_QUOTE,
    CLS_GT,
    CLS_RBRACK,
    CLS_SOLO,
    CLS_BSLASH,
    CLS_TEXT
  } cls_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } mct_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_done;
    logic [1:0] token_kind;
    logic       line_done;
    logic [7:0] token_count;
  } mct_out_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
    cls_e       cls;
  } mct_item_t;

endpackage

/* src/mct_front.sv */
module mct_front import mct_pkg::*; (
  input  logic      in_valid_i,
  input  mct_in_t   in_data_i,
  output logic      in_ready_o,
  input  logic      q_full_i,
  output logic      push_o,
  output mct_item_t item_o
);

  logic [7:0] c;
  cls_e       cls;

  assign c = in_data_i.in_byte;

  // Classify the byte: whitespace first, then specials, then control and colon, then backslash
  always_comb begin
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cls = CLS_SPACE;
    end else if (c == CH_LT) begin
      cls = CLS_LT;
    end else if (c == CH_LBRACK) begin
      cls = CLS_LBRACK;
    end else if (c == CH_QUOTE) begin
      cls = CLS_QUOTE;
    end else if (c == CH_GT) begin
      cls = CLS_GT;
    end else if (c == CH_RBRACK) begin
      cls = CLS_RBRACK;
    end else if (c < CH_SPACE || c == CH_DEL || c == CH_COLON) begin
      cls = CLS_SOLO;
    end else if (c == CH_BSLASH) begin
      cls = CLS_BSLASH;
    end else begin
      cls = CLS_TEXT;
    end
  end

  // Push classified request into the queue
  assign in_ready_o     = !q_full_i;
  assign push_o         = in_valid_i && !q_full_i;
  assign item_o.in_byte = c;
  assign item_o.is_end  = in_data_i.is_end;
  assign item_o.cls     = cls;

endmodule

/* src/mct_queue.sv */
`include "mail_command_tokenizer_core_macros.svh"

module mct_queue import mct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mct_item_t item_i,
  output logic      full_o,
  output logic      head_vld_o,
  output mct_item_t head_o,
  input  logic      pop_i
);

  mct_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  `MCT_ASSERT_NOW(a_no_pop_empty, pop_i, cnt_q != '0, "queue popped while empty")
  `MCT_ASSERT_NOW(a_no_push_full, push_i, !full_o, "queue pushed while full")
  `MCT_ASSERT_NOW(a_ptr_gap, 1'b1, (wr_ptr_q - rd_ptr_q) == QPTR_W'(cnt_q), "pointer gap mismatch")

endmodule

/* src/mct_back.sv */
`include "mail_command_tokenizer_core_macros.svh"

module mct_back import mct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_vld_i,
  input  mct_item_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mct_out_t  out_data_o
);

  logic [2:0] mode_q, mode_d;
  logic       esc_q, esc_d;
  logic [1:0] kind_q, kind_d;
  logic       lcb_q, lcb_d;
  logic [7:0] tok_q, tok_d;

  logic       out_vld_q, out_vld_d;
  mct_out_t   out_q, out_d;
  logic       pend_vld_q, pend_vld_d;
  mct_out_t   pend_q, pend_d;

  mct_out_t   r0, r1, idle_r;
  logic       v0, v1, idle_v, do_idle, is_closer, slot_free, fire;
  logic [7:0] c;
  logic [7:0] end_cnt;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v < TOKEN_LIMIT) ? v + 8'd1 : v;
  endfunction

  assign c         = head_i.in_byte;
  assign slot_free = !out_vld_q || out_ready_i;
  assign fire      = head_vld_i && !pend_vld_q && slot_free;
  assign pop_o     = fire;

  // Tokenizer step: up to two results per request
  always_comb begin
    mode_d    = mode_q;
    esc_d     = esc_q;
    kind_d    = kind_q;
    lcb_d     = lcb_q;
    tok_d     = tok_q;
    r0        = '0;
    r1        = '0;
    v0        = 1'b0;
    v1        = 1'b0;
    idle_r    = '0;
    idle_v    = 1'b0;
    do_idle   = 1'b0;
    end_cnt   = tok_q;
    is_closer = 1'b0;

    if (head_i.is_end) begin
      // Close any open token and report the line
      v0           = 1'b1;
      r0.line_done = 1'b1;
      case (mode_q)
        MODE_PLAIN: begin
          end_cnt       = sat_inc(tok_q);
          r0.token_done = 1'b1;
          r0.token_kind = KIND_PLAIN;
        end
        MODE_LIT, MODE_LIT_Q: begin
          end_cnt       = sat_inc(tok_q);
          r0.token_done = 1'b1;
          r0.token_kind = KIND_BAD;
          if (lcb_q) begin
            r0.out_byte = CH_RBRACK;
            r0.has_byte = 1'b1;
          end
        end
        MODE_ADDR, MODE_ADDR_Q, MODE_QSTR: begin
          end_cnt       = sat_inc(tok_q);
          r0.token_done = 1'b1;
          r0.token_kind = KIND_BAD;
        end
        default: begin
          end_cnt = tok_q;
        end
      endcase
      r0.token_count = end_cnt;
      mode_d = MODE_IDLE;
      esc_d  = 1'b0;
      kind_d = KIND_PLAIN;
      lcb_d  = 1'b0;
      tok_d  = '0;
    end else if (mode_q == MODE_PLAIN) begin
      if (esc_q) begin
        esc_d       = 1'b0;
        v0          = 1'b1;
        r0.out_byte = c;
        r0.has_byte = 1'b1;
      end else if (head_i.cls == CLS_BSLASH) begin
        esc_d = 1'b1;
      end else if (head_i.cls == CLS_TEXT) begin
        v0          = 1'b1;
        r0.out_byte = c;
        r0.has_byte = 1'b1;
      end else begin
        // Terminator ends the token, then is taken between tokens
        tok_d         = sat_inc(tok_q);
        v0            = 1'b1;
        r0.token_done = 1'b1;
        r0.token_kind = KIND_PLAIN;
        do_idle       = 1'b1;
      end
    end else if (mode_q >= MODE_ADDR && mode_q <= MODE_QSTR) begin
      if (mode_q == MODE_ADDR) begin
        is_closer = (head_i.cls == CLS_GT);
      end else if (mode_q == MODE_LIT) begin
        is_closer = (head_i.cls == CLS_RBRACK);
      end else begin
        is_closer = (head_i.cls == CLS_QUOTE);
      end
      if (esc_q) begin
        esc_d       = 1'b0;
        v0          = 1'b1;
        r0.out_byte = c;
        r0.has_byte = 1'b1;
      end else if (head_i.cls == CLS_BSLASH) begin
        esc_d = 1'b1;
      end else if (is_closer) begin
        case (mode_q)
          MODE_ADDR_Q: begin
            mode_d = MODE_ADDR;
          end
          MODE_LIT_Q: begin
            mode_d = MODE_LIT;
          end
          MODE_LIT: begin
            tok_d         = sat_inc(tok_q);
            v0            = 1'b1;
            r0.out_byte   = CH_RBRACK;
            r0.has_byte   = 1'b1;
            r0.token_done = 1'b1;
            r0.token_kind = kind_q;
            mode_d        = MODE_IDLE;
          end
          default: begin
            tok_d         = sat_inc(tok_q);
            v0            = 1'b1;
            r0.token_done = 1'b1;
            r0.token_kind = kind_q;
            mode_d        = MODE_IDLE;
          end
        endcase
      end else if (head_i.cls == CLS_QUOTE) begin
        mode_d = (mode_q == MODE_ADDR) ? MODE_ADDR_Q : MODE_LIT_Q;
      end else begin
        v0          = 1'b1;
        r0.out_byte = c;
        r0.has_byte = 1'b1;
      end
      if (mode_q == MODE_LIT || mode_q == MODE_LIT_Q) begin
        lcb_d = (head_i.cls == CLS_RBRACK);
      end
    end else begin
      do_idle = 1'b1;
    end

    // Take a byte between tokens
    if (do_idle) begin
      esc_d = 1'b0;
      case (head_i.cls)
        CLS_SPACE: begin
          mode_d = MODE_IDLE;
        end
        CLS_LT: begin
          mode_d = MODE_ADDR;
          kind_d = KIND_ADDR;
        end
        CLS_LBRACK: begin
          mode_d          = MODE_LIT;
          kind_d          = KIND_PLAIN;
          lcb_d           = 1'b0;
          idle_v          = 1'b1;
          idle_r.out_byte = c;
          idle_r.has_byte = 1'b1;
        end
        CLS_QUOTE: begin
          mode_d = MODE_QSTR;
          kind_d = KIND_PLAIN;
        end
        CLS_GT, CLS_RBRACK, CLS_SOLO: begin
          mode_d            = MODE_IDLE;
          tok_d             = sat_inc(tok_d);
          idle_v            = 1'b1;
          idle_r.out_byte   = c;
          idle_r.has_byte   = 1'b1;
          idle_r.token_done = 1'b1;
          idle_r.token_kind = KIND_PLAIN;
        end
        CLS_BSLASH: begin
          mode_d = MODE_PLAIN;
          kind_d = KIND_PLAIN;
          esc_d  = 1'b1;
        end
        default: begin
          mode_d          = MODE_PLAIN;
          kind_d          = KIND_PLAIN;
          idle_v          = 1'b1;
          idle_r.out_byte = c;
          idle_r.has_byte = 1'b1;
        end
      endcase
      if (idle_v) begin
        if (v0) begin
          v1 = 1'b1;
          r1 = idle_r;
        end else begin
          v0 = 1'b1;
          r0 = idle_r;
        end
      end
    end
  end

  // Fill output register, second result waits in the pending slot
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    if (slot_free) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = pend_q;
        pend_vld_d = 1'b0;
      end else if (head_vld_i) begin
        out_vld_d  = v0;
        out_d      = r0;
        pend_vld_d = v1;
        pend_d     = r1;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  // Hold scan state and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      esc_q      <= 1'b0;
      kind_q     <= KIND_PLAIN;
      lcb_q      <= 1'b0;
      tok_q      <= '0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_q <= mode_d;
        esc_q  <= esc_d;
        kind_q <= kind_d;
        lcb_q  <= lcb_d;
        tok_q  <= tok_d;
      end
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `MCT_ASSERT_NOW(a_pend_behind_out, pend_vld_q, out_vld_q, "pending result without output")
  `MCT_ASSERT_NOW(a_esc_in_token, esc_q, mode_q != MODE_IDLE, "escape pending between tokens")
  `MCT_ASSERT_NOW(a_kind_only_done, out_vld_q && !out_q.token_done,
                  out_q.token_kind == KIND_PLAIN, "kind set on unfinished token")
  `MCT_ASSERT_NEXT(a_end_resets, fire && head_i.is_end,
                   mode_q == MODE_IDLE && tok_q == '0, "line end left state behind")

endmodule

/* src/mail_command_tokenizer_core.sv */
// Mail command line tokenizer.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one byte of the
// command line per request, or an end-of-line marker (is_end set). Output
// channel (out_valid_o / out_ready_i / out_data_o) delivers the token stream:
// text bytes, token ends with their kind, and one line-done result carrying
// the saturating token count.
// A request passes through the queue and then the output register. The back
// end takes one byte per cycle unless the receiver stalls; a byte that ends
// a plain token and also starts a one-character token or literal yields two
// results, and the second waits in the pending slot while the back end takes
// no new byte. The classifier and the scan engine are parted by a four-entry
// queue, so the input keeps taking bytes while the back end is held or the
// receiver stalls; input ready drops only when that queue is full.
// Reset empties the queue and the output register and puts the scanner
// between tokens with a count of zero. A stalled receiver holds the current
// result in the output register until it is taken.
module mail_command_tokenizer_core import mct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mct_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mct_out_t out_data_o
);

  logic      q_full, push, head_vld, pop;
  mct_item_t item, head;

  mct_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (item)
  );

  mct_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item),
    .full_o     (q_full),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  mct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
